@@ rtl/lcd4_pkg.sv @@
// Shared types, action codes and command tables for the 4-bit character-LCD sequencer.
// Depends on nothing; imported by every module of the block.
package lcd4_pkg;

   // Request action codes
   localparam logic [3:0] ACT_INIT    = 4'd0;
   localparam logic [3:0] ACT_RAW     = 4'd1;
   localparam logic [3:0] ACT_DATA    = 4'd2;
   localparam logic [3:0] ACT_CLEAR   = 4'd3;
   localparam logic [3:0] ACT_HOME    = 4'd4;
   localparam logic [3:0] ACT_CURSOR  = 4'd5;
   localparam logic [3:0] ACT_DISP_EN = 4'd6;
   localparam logic [3:0] ACT_CURS_EN = 4'd7;
   localparam logic [3:0] ACT_BLINK   = 4'd8;

   // Result kinds
   localparam logic KIND_WRITE = 1'b0;
   localparam logic KIND_POLL  = 1'b1;

   // Command bytes
   localparam logic [7:0] CMD_CLEAR    = 8'h01;
   localparam logic [7:0] CMD_HOME     = 8'h02;
   localparam logic [7:0] CMD_ENTRY    = 8'h06;
   localparam logic [7:0] CMD_DISP_CTL = 8'h08;
   localparam logic [7:0] CMD_SET_ADDR = 8'h80;

   // Flag bit positions
   localparam int FLAG_DISPLAY = 2;
   localparam int FLAG_CURSOR  = 1;
   localparam int FLAG_BLINK   = 0;

   // Sequencer step indexes
   localparam logic [4:0] STEP_PLAIN_LAST = 5'd2;
   localparam logic [4:0] STEP_INIT_LAST  = 5'd17;

   typedef struct packed {
      logic [3:0] action;
      logic [7:0] byte_value;
      logic [1:0] row;
      logic [5:0] col;
      logic       turn_on;
   } req_type;

   typedef struct packed {
      logic        kind;
      logic        reg_select;
      logic        read_write;
      logic [3:0]  nibble;
      logic [12:0] wait_after_us;
      logic        last;
   } rsp_type;

   // One classified request waiting for the bus sequencer
   typedef struct packed {
      logic       init;
      logic       reg_select;
      logic [7:0] byte_value;
   } cmd_type;

   function automatic logic [6:0] row_base(input logic [1:0] row);
      logic [6:0] base;
      unique case (row)
         2'd0:    base = 7'h00;
         2'd1:    base = 7'h40;
         2'd2:    base = 7'h14;
         default: base = 7'h54;
      endcase
      return base;
   endfunction

   // Byte write as hi nibble, lo nibble, then busy poll
   function automatic rsp_type byte_item(input logic [1:0] phase, input logic rs,
                                         input logic [7:0] value, input logic final_byte);
      rsp_type r;
      r.kind          = KIND_WRITE;
      r.reg_select    = rs;
      r.read_write    = 1'b0;
      r.nibble        = value[7:4];
      r.wait_after_us = 13'd0;
      r.last          = 1'b0;
      unique case (phase)
         2'd0: r.nibble = value[7:4];
         2'd1: r.nibble = value[3:0];
         default: begin
            r.kind       = KIND_POLL;
            r.reg_select = 1'b0;
            r.read_write = 1'b1;
            r.nibble     = 4'd0;
            r.last       = final_byte;
         end
      endcase
      return r;
   endfunction

   // Init sequence: six timed nibbles, then four command bytes
   function automatic rsp_type init_item(input logic [4:0] step, input logic [7:0] final_cmd);
      rsp_type    r;
      logic [7:0] value;
      logic [1:0] phase;
      r.kind          = KIND_WRITE;
      r.reg_select    = 1'b0;
      r.read_write    = 1'b0;
      r.nibble        = 4'd0;
      r.wait_after_us = 13'd0;
      r.last          = 1'b0;
      if (step < 5'd9)       value = CMD_DISP_CTL;
      else if (step < 5'd12) value = CMD_CLEAR;
      else if (step < 5'd15) value = CMD_ENTRY;
      else                   value = final_cmd;
      unique case (step)
         5'd6, 5'd9, 5'd12, 5'd15:  phase = 2'd0;
         5'd7, 5'd10, 5'd13, 5'd16: phase = 2'd1;
         default:                   phase = 2'd2;
      endcase
      unique case (step)
         5'd0: begin r.nibble = 4'h3; r.wait_after_us = 13'd4500; end
         5'd1: begin r.nibble = 4'h3; r.wait_after_us = 13'd500;  end
         5'd2: begin r.nibble = 4'h3; r.wait_after_us = 13'd250;  end
         5'd3: begin r.nibble = 4'h2; r.wait_after_us = 13'd2000; end
         5'd4: begin r.nibble = 4'h2; r.wait_after_us = 13'd150;  end
         5'd5: begin r.nibble = 4'h8; r.wait_after_us = 13'd150;  end
         default: r = byte_item(phase, 1'b0, value, step == STEP_INIT_LAST);
      endcase
      return r;
   endfunction

endpackage

@@ rtl/lcd4_front.sv @@
// Request front end: decodes actions, keeps the display-control flags, builds commands.
// Depends on lcd4_pkg.
module lcd4_front import lcd4_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  req_type req,
   input  logic    queue_full,
   output logic    req_stall,
   output logic    push,
   output cmd_type push_cmd
);

   logic [2:0] flags_ff, flags_in;
   logic       accept;
   logic [6:0] addr;
   logic [2:0] flag_bit;

   assign req_stall = queue_full;
   assign accept    = req_valid & ~queue_full;
   assign addr      = 7'({1'b0, req.col} + row_base(req.row));

   always_comb begin
      flags_in  = flags_ff;
      push      = 1'b0;
      push_cmd  = '0;
      flag_bit  = 3'b000;
      unique case (req.action)
         ACT_DISP_EN: flag_bit[FLAG_DISPLAY] = 1'b1;
         ACT_CURS_EN: flag_bit[FLAG_CURSOR]  = 1'b1;
         ACT_BLINK:   flag_bit[FLAG_BLINK]   = 1'b1;
         default:     flag_bit = 3'b000;
      endcase
      if (accept) begin
         unique case (req.action)
            ACT_INIT: begin
               flags_in = flags_ff | 3'b100;
               push     = 1'b1;
               push_cmd = '{init: 1'b1, reg_select: 1'b0,
                            byte_value: CMD_DISP_CTL | {5'd0, flags_in}};
            end
            ACT_RAW: begin
               push     = 1'b1;
               push_cmd = '{init: 1'b0, reg_select: 1'b0, byte_value: req.byte_value};
            end
            ACT_DATA: begin
               push     = 1'b1;
               push_cmd = '{init: 1'b0, reg_select: 1'b1, byte_value: req.byte_value};
            end
            ACT_CLEAR: begin
               push     = 1'b1;
               push_cmd = '{init: 1'b0, reg_select: 1'b0, byte_value: CMD_CLEAR};
            end
            ACT_HOME: begin
               push     = 1'b1;
               push_cmd = '{init: 1'b0, reg_select: 1'b0, byte_value: CMD_HOME};
            end
            ACT_CURSOR: begin
               push     = 1'b1;
               push_cmd = '{init: 1'b0, reg_select: 1'b0,
                            byte_value: CMD_SET_ADDR | {1'b0, addr}};
            end
            ACT_DISP_EN, ACT_CURS_EN, ACT_BLINK: begin
               flags_in = req.turn_on ? (flags_ff | flag_bit) : (flags_ff & ~flag_bit);
               push     = 1'b1;
               push_cmd = '{init: 1'b0, reg_select: 1'b0,
                            byte_value: CMD_DISP_CTL | {5'd0, flags_in}};
            end
            default: push = 1'b0;  // drop unknown actions
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) flags_ff <= 3'b000;
      else       flags_ff <= flags_in;
   end

endmodule

@@ rtl/lcd4_queue.sv @@
// Two-entry command queue between the front end and the bus sequencer.
// Depends on lcd4_pkg.
module lcd4_queue import lcd4_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   input  logic    pop,
   output cmd_type head,
   output logic    full,
   output logic    empty
);

   cmd_type    slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign head  = slot_ff[rd_ptr_ff];
   assign full  = count_ff == 2'd2;
   assign empty = count_ff == 2'd0;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = 2'(count_ff + {1'b0, push} - {1'b0, pop});
   end

   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ptr_ff] <= push_cmd;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

@@ rtl/lcd4_back.sv @@
// Bus sequencer: expands one queued command into nibble writes and busy polls.
// Depends on lcd4_pkg.
module lcd4_back import lcd4_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  cmd_type head,
   input  logic    empty,
   output logic    pop,
   output logic    rsp_valid,
   output rsp_type rsp,
   input  logic    rsp_stall
);

   logic       active_ff, active_in;
   logic [4:0] step_ff, step_in;
   cmd_type    cmd_ff, cmd_in;
   logic       rsp_valid_ff, rsp_valid_in;
   rsp_type    rsp_ff, rsp_in;
   rsp_type    item;
   logic       load;

   assign load      = ~rsp_valid_ff | ~rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   always_comb begin
      if (cmd_ff.init) item = init_item(step_ff, cmd_ff.byte_value);
      else             item = byte_item(step_ff[1:0], cmd_ff.reg_select,
                                        cmd_ff.byte_value, step_ff == STEP_PLAIN_LAST);
   end

   always_comb begin
      active_in    = active_ff;
      step_in      = step_ff;
      cmd_in       = cmd_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      pop          = 1'b0;
      if (load) begin
         rsp_valid_in = active_ff;
         if (active_ff) begin
            rsp_in = item;
            if (item.last) active_in = 1'b0;
            else           step_in   = 5'(step_ff + 5'd1);
         end
      end
      if (!active_ff && !empty) begin
         pop       = 1'b1;
         cmd_in    = head;
         active_in = 1'b1;
         step_in   = 5'd0;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
      rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         step_ff      <= 5'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

@@ rtl/char_lcd_4bit_command_sequencer.sv @@
// Top level of the 4-bit character-LCD request sequencer.
// A request's first transfer passes through the queue slot, the command load and the output register.
// Throughput: one transfer per cycle from the sequencer step counter while the result side does not
// stall, plus a load step per request in which no transfer is issued.
// Reset: synchronous, active high; clears display flags, queue and sequencer, drops results.
// Depends on lcd4_pkg, lcd4_front, lcd4_queue, lcd4_back.
module char_lcd_4bit_command_sequencer import lcd4_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  req_type req,
   output logic    req_stall,
   output logic    rsp_valid,
   output rsp_type rsp,
   input  logic    rsp_stall
);

   // Front end to queue
   logic    push;
   cmd_type push_cmd;
   logic    queue_full;

   // Queue to sequencer
   cmd_type head;
   logic    empty;
   logic    pop;

   // Decode requests and track flags; stall only when the queue is full
   lcd4_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req        (req),
      .queue_full (queue_full),
      .req_stall  (req_stall),
      .push       (push),
      .push_cmd   (push_cmd)
   );

   // Hold classified commands so requests keep flowing while the bus is busy
   lcd4_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .head     (head),
      .full     (queue_full),
      .empty    (empty)
   );

   // Step through nibble writes and polls; advance only when the output register frees up
   lcd4_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .empty     (empty),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp       (rsp),
      .rsp_stall (rsp_stall)
   );

endmodule

@@ tb/lcd4_checker.sv @@
// Transfer predictor and scoreboard for the 4-bit character-LCD request sequencer.
// Watches both channels of the block; depends on lcd4_pkg only.
module lcd4_checker import lcd4_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  req_type req,
   input  logic    req_stall,
   input  logic    rsp_valid,
   input  rsp_type rsp,
   input  logic    rsp_stall,
   output int      error_count,
   output int      outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   rsp_type    bus_xfers[$];
   logic [2:0] panel_flags;
   rsp_type    want;
   int         mismatches;

   function automatic rsp_type make_xfer(input logic kind, input logic rs, input logic rw,
                                         input logic [3:0] nib, input logic [12:0] wait_us,
                                         input logic last_one);
      rsp_type x;
      x.kind          = kind;
      x.reg_select    = rs;
      x.read_write    = rw;
      x.nibble        = nib;
      x.wait_after_us = wait_us;
      x.last          = last_one;
      return x;
   endfunction

   // High nibble, low nibble, then the busy poll
   task automatic queue_byte(input logic [7:0] value, input logic rs, input logic final_byte);
      bus_xfers.push_back(make_xfer(KIND_WRITE, rs, 1'b0, value[7:4], 13'd0, 1'b0));
      bus_xfers.push_back(make_xfer(KIND_WRITE, rs, 1'b0, value[3:0], 13'd0, 1'b0));
      bus_xfers.push_back(make_xfer(KIND_POLL, 1'b0, 1'b1, 4'd0, 13'd0, final_byte));
   endtask

   task automatic predict_transfers(input req_type r);
      logic [3:0]  nib;
      logic [12:0] wait_us;
      logic [6:0]  offset;
      logic [6:0]  addr;
      int          flag_idx;
      case (r.action)
         ACT_INIT: begin
            for (int i = 0; i < 6; i++) begin
               case (i)
                  0:       begin nib = 4'h3; wait_us = 13'd4500; end
                  1:       begin nib = 4'h3; wait_us = 13'd500;  end
                  2:       begin nib = 4'h3; wait_us = 13'd250;  end
                  3:       begin nib = 4'h2; wait_us = 13'd2000; end
                  4:       begin nib = 4'h2; wait_us = 13'd150;  end
                  default: begin nib = 4'h8; wait_us = 13'd150;  end
               endcase
               bus_xfers.push_back(make_xfer(KIND_WRITE, 1'b0, 1'b0, nib, wait_us, 1'b0));
            end
            queue_byte(CMD_DISP_CTL, 1'b0, 1'b0);
            queue_byte(CMD_CLEAR, 1'b0, 1'b0);
            queue_byte(CMD_ENTRY, 1'b0, 1'b0);
            panel_flags[FLAG_DISPLAY] = 1'b1;
            queue_byte(CMD_DISP_CTL | {5'd0, panel_flags}, 1'b0, 1'b1);
         end
         ACT_RAW:   queue_byte(r.byte_value, 1'b0, 1'b1);
         ACT_DATA:  queue_byte(r.byte_value, 1'b1, 1'b1);
         ACT_CLEAR: queue_byte(CMD_CLEAR, 1'b0, 1'b1);
         ACT_HOME:  queue_byte(CMD_HOME, 1'b0, 1'b1);
         ACT_CURSOR: begin
            case (r.row)
               2'd0:    offset = 7'h00;
               2'd1:    offset = 7'h40;
               2'd2:    offset = 7'h14;
               default: offset = 7'h54;
            endcase
            // wraps silently to 7 bits
            addr = {1'b0, r.col} + offset;
            queue_byte(CMD_SET_ADDR | {1'b0, addr}, 1'b0, 1'b1);
         end
         ACT_DISP_EN, ACT_CURS_EN, ACT_BLINK: begin
            if (r.action == ACT_DISP_EN)      flag_idx = FLAG_DISPLAY;
            else if (r.action == ACT_CURS_EN) flag_idx = FLAG_CURSOR;
            else                              flag_idx = FLAG_BLINK;
            panel_flags[flag_idx] = r.turn_on;
            queue_byte(CMD_DISP_CTL | {5'd0, panel_flags}, 1'b0, 1'b1);
         end
         default: ;
      endcase
   endtask

   function automatic int field_diff(input string name, input int unsigned exp_val,
                                     input int unsigned act_val);
      if (exp_val == act_val) return 0;
      $error("%s mismatch: expected %0d, actual %0d", name, exp_val, act_val);
      return 1;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         bus_xfers.delete();
         panel_flags = '0;
      end else begin
         // check first: a transfer always belongs to an earlier request
         if (rsp_valid && !rsp_stall) begin
            if (bus_xfers.size() == 0) begin
               $error("unexpected transfer: nibble %0h kind %0d", rsp.nibble, rsp.kind);
               mismatches++;
            end else begin
               want = bus_xfers.pop_front();
               mismatches += field_diff("kind", want.kind, rsp.kind);
               mismatches += field_diff("reg_select", want.reg_select, rsp.reg_select);
               mismatches += field_diff("read_write", want.read_write, rsp.read_write);
               mismatches += field_diff("nibble", want.nibble, rsp.nibble);
               mismatches += field_diff("wait_after_us", want.wait_after_us, rsp.wait_after_us);
               mismatches += field_diff("last", want.last, rsp.last);
            end
         end
         if (req_valid && !req_stall) predict_transfers(req);
      end
      error_count <= mismatches;
      outstanding <= bus_xfers.size();
   end

endmodule

@@ tb/testbench.sv @@
// Top of the testbench for the 4-bit character-LCD request sequencer.
// Drives requests and result stalls, gives the verdict; depends on lcd4_pkg, lcd4_checker
// and the block itself.
module testbench;
   import lcd4_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   // Worst case is far below this: ~150 requests of at most 18 transfers each, plus the hold-off
   localparam int CYCLE_LIMIT  = 200000;
   localparam int HOLD_CYCLES  = 300;
   localparam int RANDOM_ITEMS = 120;

   logic    clock;
   logic    reset;
   logic    req_valid;
   req_type req;
   logic    req_stall;
   logic    rsp_valid;
   rsp_type rsp;
   logic    rsp_stall;

   int error_count;
   int outstanding;
   int cycle_count;

   // Shared between the two drivers: quiet turns off all idling, hold_off_req asks
   // the receiver for one long stall.
   bit quiet;
   bit hold_off_req;

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   char_lcd_4bit_command_sequencer u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req       (req),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp       (rsp),
      .rsp_stall (rsp_stall)
   );

   lcd4_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req         (req),
      .req_stall   (req_stall),
      .rsp_valid   (rsp_valid),
      .rsp         (rsp),
      .rsp_stall   (rsp_stall),
      .error_count (error_count),
      .outstanding (outstanding)
   );

   // Give up at the cycle limit: something is hung.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   function automatic req_type make_req(input logic [3:0] action, input logic [7:0] value,
                                        input logic [1:0] row, input logic [5:0] col,
                                        input logic turn_on);
      req_type r;
      r.action     = action;
      r.byte_value = value;
      r.row        = row;
      r.col        = col;
      r.turn_on    = turn_on;
      return r;
   endfunction

   // Offer one request and hold it until the transfer happens. Valid is only
   // dropped for an idle burst, never in the same step it is raised again.
   task automatic send_request(input req_type item);
      req       <= item;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   // Result side: random stall bursts, one long hold-off on request, none once quiet.
   initial begin
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_req) begin
            hold_off_req = 1'b0;
            rsp_stall <= 1'b1;
            // hold long enough for the block to fill up and stall its input
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_stall <= 1'b0;
         end else if (!quiet && $urandom_range(0, 7) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 6)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin
      req_type item;
      int      counted;
      int      pick;

      quiet        = 1'b0;
      hold_off_req = 1'b0;
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req       <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed part: init first, then every action and the field extremes.
      send_request(make_req(ACT_INIT, 8'h00, 2'd0, 6'd0, 1'b0));
      send_request(make_req(ACT_RAW, 8'h00, 2'd0, 6'd0, 1'b0));
      send_request(make_req(ACT_RAW, 8'hFF, 2'd0, 6'd0, 1'b0));
      send_request(make_req(ACT_DATA, 8'h5A, 2'd0, 6'd0, 1'b0));
      send_request(make_req(ACT_DATA, 8'hA5, 2'd3, 6'd63, 1'b1));
      send_request(make_req(ACT_CLEAR, 8'h00, 2'd0, 6'd0, 1'b0));
      send_request(make_req(ACT_HOME, 8'h00, 2'd0, 6'd0, 1'b0));
      send_request(make_req(ACT_CURSOR, 8'h00, 2'd0, 6'd0, 1'b0));
      send_request(make_req(ACT_CURSOR, 8'h00, 2'd1, 6'd39, 1'b0));
      send_request(make_req(ACT_CURSOR, 8'h00, 2'd2, 6'd21, 1'b0));
      send_request(make_req(ACT_CURSOR, 8'h00, 2'd3, 6'd39, 1'b0));
      // column past the line end: the address wraps to 7 bits
      send_request(make_req(ACT_CURSOR, 8'h00, 2'd3, 6'd63, 1'b0));
      send_request(make_req(ACT_CURSOR, 8'h00, 2'd1, 6'd63, 1'b0));
      send_request(make_req(ACT_DISP_EN, 8'h00, 2'd0, 6'd0, 1'b0));
      send_request(make_req(ACT_CURS_EN, 8'h00, 2'd0, 6'd0, 1'b1));
      send_request(make_req(ACT_BLINK, 8'h00, 2'd0, 6'd0, 1'b1));
      send_request(make_req(ACT_DISP_EN, 8'h00, 2'd0, 6'd0, 1'b1));
      send_request(make_req(ACT_BLINK, 8'h00, 2'd0, 6'd0, 1'b0));
      send_request(make_req(ACT_CURS_EN, 8'h00, 2'd0, 6'd0, 1'b0));
      // unknown actions: no transfers, flags untouched
      send_request(make_req(4'd9, 8'hFF, 2'd3, 6'd63, 1'b1));
      send_request(make_req(4'd15, 8'h00, 2'd0, 6'd0, 1'b1));
      send_request(make_req(ACT_DISP_EN, 8'h00, 2'd0, 6'd0, 1'b1));
      send_request(make_req(ACT_INIT, 8'hFF, 2'd3, 6'd63, 1'b1));

      // Random part: mostly real requests with random content, a few re-inits,
      // a sprinkle of unknown actions that do not count.
      counted = 0;
      while (counted < RANDOM_ITEMS) begin
         item.byte_value = 8'($urandom_range(0, 255));
         item.row        = 2'($urandom_range(0, 3));
         item.col        = ($urandom_range(0, 7) == 0) ? 6'($urandom_range(40, 63))
                                                       : 6'($urandom_range(0, 39));
         item.turn_on    = 1'($urandom_range(0, 1));
         pick = $urandom_range(0, 99);
         if (pick < 4)       item.action = ACT_INIT;
         else if (pick < 9)  item.action = 4'($urandom_range(9, 15));
         else                item.action = 4'($urandom_range(1, 8));
         if (item.action <= ACT_BLINK) counted++;
         if (counted == 40 && item.action <= ACT_BLINK) hold_off_req = 1'b1;
         // drop all idling for the tail of the run
         if (counted == RANDOM_ITEMS - 30) quiet = 1'b1;
         send_request(item);
      end
      req_valid <= 1'b0;

      // Drain expectations, then linger to catch stray transfers.
      do @(posedge clock); while (outstanding != 0);
      repeat (25) @(posedge clock);
      if (error_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
